// File: sv/gdr_pkg.sv
package gdr_pkg;

    localparam int MAP_BITS       = 6;
    localparam int MAP_DIM        = 1 << MAP_BITS;
    localparam int MAP_DEPTH      = MAP_DIM * MAP_DIM;
    localparam int MX_W           = MAP_BITS + 2;
    localparam int MAX_SCREEN_DIM = 2048;
    localparam int LH_MAX         = 2 * MAX_SCREEN_DIM;
    localparam int LH_W           = $clog2(LH_MAX) + 1;
    localparam int DIV_NW         = 31;
    localparam int DIV_DW         = 48;
    localparam int SD_W           = 48;
    localparam int DD_W           = 41;
    localparam int CAM_W          = 28;
    localparam int RD_W           = 30;

    localparam logic [DD_W-1:0]   DELTA_INF = {1'b1, {(DD_W-1){1'b0}}};
    localparam logic [DIV_NW-1:0] ONE_Q30   = {1'b1, 30'b0};
    localparam logic [23:0]       DIST_MAX  = 24'hFFFFFF;

    localparam logic [1:0] DIV_CAM = 2'd0;
    localparam logic [1:0] DIV_DX  = 2'd1;
    localparam logic [1:0] DIV_DY  = 2'd2;
    localparam logic [1:0] DIV_LH  = 2'd3;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_WIDTH   = 3'd6;
    localparam logic [2:0] CFG_HEIGHT  = 3'd7;

    typedef struct packed {
        logic        command;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [7:0]  cell_value;
        logic [10:0] column;
    } t_in_word;

    typedef struct packed {
        logic [10:0] out_column;
        logic [10:0] draw_start;
        logic [10:0] draw_end;
        logic [7:0]  wall_type;
        logic        hit_side;
        logic [23:0] wall_distance;
        logic        left_map;
    } t_out_word;

    typedef struct packed {
        logic       accept_write;
        logic       accept_cast;
        logic       div_start;
        logic [1:0] div_sel;
        logic       cam_load;
        logic       mul_load;
        logic       rd_load;
        logic       dx_load;
        logic       dy_load;
        logic       sd_load;
        logic       step;
        logic       wall_load;
        logic       lh_load;
        logic       mark_left;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic start_out;
        logic step_out;
        logic wall_nz;
        logic out_free;
    } t_stat;

endpackage

// File: sv/gdr_ram.sv
module gdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gdr_div.sv
module gdr_div
    import gdr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_DW:0]   c_sh;
    logic [DIV_DW:0]   c_diff;
    logic              c_ge;

    // restoring division, one quotient bit a cycle
    assign c_sh   = {r_rem, r_quo[DIV_NW-1]};
    assign c_ge   = c_sh >= {1'b0, r_dvs};
    assign c_diff = c_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= c_ge ? c_diff[DIV_DW-1:0] : c_sh[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], c_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: sv/gdr_datapath.sv
module gdr_datapath
    import gdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  t_in_word    i_in_word,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output t_out_word   o_out_word
);

    logic [23:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [11:0]        r_width, r_height;

    logic [10:0]              r_col;
    logic [11:0]              r_w, r_h;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [43:0]       r_prod_x, r_prod_y;
    logic signed [RD_W-1:0]   r_rdx, r_rdy;
    logic [DD_W-1:0]          r_ddx, r_ddy;
    logic [SD_W-1:0]          r_sdx, r_sdy;
    logic signed [MX_W-1:0]   r_mx, r_my;
    logic                     r_side;
    logic [7:0]               r_wall;
    logic                     r_left;
    logic [LH_W-1:0]          r_lh;
    logic                     r_out_valid;
    t_out_word                r_out;

    logic signed [12:0]  c_num;
    logic [11:0]         c_num_mag;
    logic [CAM_W-1:0]    c_cam_mag;
    logic signed [43:0]  c_trx, c_try;
    logic [RD_W-1:0]     c_rdx_mag, c_rdy_mag;
    logic [16:0]         c_fracx, c_fracy;
    logic [47:0]         c_pmx, c_pmy;
    logic                c_take_x;
    logic signed [MX_W-1:0] c_mx, c_my;
    logic [SD_W-1:0]     c_perp;
    logic [10:0]         c_hh;
    logic [11:0]         c_lh2;
    logic [12:0]         c_end_sum;
    logic [10:0]         c_start, c_end;
    logic [23:0]         c_dist;
    logic [DIV_NW-1:0]   c_dividend;
    logic [DIV_DW-1:0]   c_divisor;
    logic                w_div_done;
    logic [DIV_NW-1:0]   w_quo;
    logic [7:0]          w_rdata;

    function automatic logic [11:0] clamp_dim(input logic [11:0] v);
        logic [11:0] r;
        if (v == 12'd0) begin
            r = 12'd1;
        end else if (v > 12'(MAX_SCREEN_DIM)) begin
            r = 12'(MAX_SCREEN_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= '0;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= '0;
            r_width   <= 12'd640;
            r_height  <= 12'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[15:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[15:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[15:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[15:0];
                CFG_WIDTH:   r_width   <= i_cfg_data[11:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[11:0];
            endcase
        end
    end

    // camera offset numerator 2*col - w
    assign c_num     = $signed({1'b0, r_col, 1'b0}) - $signed({1'b0, r_w});
    assign c_num_mag = c_num[12] ? 12'(-c_num) : c_num[11:0];
    assign c_cam_mag = {1'b0, w_quo[CAM_W-2:0]};

    // plane * cam / 2^14, truncated toward zero
    assign c_trx = r_prod_x[43] ? ((r_prod_x + 44'sd16383) >>> 14) : (r_prod_x >>> 14);
    assign c_try = r_prod_y[43] ? ((r_prod_y + 44'sd16383) >>> 14) : (r_prod_y >>> 14);

    assign c_rdx_mag = r_rdx[RD_W-1] ? RD_W'(-r_rdx) : r_rdx;
    assign c_rdy_mag = r_rdy[RD_W-1] ? RD_W'(-r_rdy) : r_rdy;

    assign c_fracx = r_rdx[RD_W-1] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign c_fracy = r_rdy[RD_W-1] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};
    assign c_pmx   = c_fracx * r_ddx[30:0];
    assign c_pmy   = c_fracy * r_ddy[30:0];

    // next cell of the walk, ties step along y
    assign c_take_x = r_sdx < r_sdy;
    always_comb begin
        c_mx = r_mx;
        c_my = r_my;
        if (c_take_x) begin
            c_mx = r_rdx[RD_W-1] ? r_mx - MX_W'(1) : r_mx + MX_W'(1);
        end else begin
            c_my = r_rdy[RD_W-1] ? r_my - MX_W'(1) : r_my + MX_W'(1);
        end
    end

    assign c_perp = r_side ? r_sdy - SD_W'(r_ddy) : r_sdx - SD_W'(r_ddx);

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_CAM: begin
                c_dividend = DIV_NW'({c_num_mag, 14'b0});
                c_divisor  = DIV_DW'(r_w);
            end
            DIV_DX: begin
                c_dividend = ONE_Q30;
                c_divisor  = DIV_DW'(c_rdx_mag);
            end
            DIV_DY: begin
                c_dividend = ONE_Q30;
                c_divisor  = DIV_DW'(c_rdy_mag);
            end
            DIV_LH: begin
                c_dividend = DIV_NW'({r_h, 16'b0});
                c_divisor  = c_perp;
            end
        endcase
    end

    gdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (c_dividend),
        .i_divisor  (c_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    gdr_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept_write),
        .i_waddr ({i_in_word.cell_x, i_in_word.cell_y}),
        .i_wdata (i_in_word.cell_value),
        .i_re    (i_cmd.step),
        .i_raddr ({c_mx[MAP_BITS-1:0], c_my[MAP_BITS-1:0]}),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_cast) begin
            r_col <= i_in_word.column;
            r_w   <= clamp_dim(r_width);
            r_h   <= clamp_dim(r_height);
        end
        if (i_cmd.cam_load) begin
            r_cam <= c_num[12] ? -$signed(c_cam_mag) : $signed(c_cam_mag);
        end
        if (i_cmd.mul_load) begin
            r_prod_x <= r_plane_x * r_cam;
            r_prod_y <= r_plane_y * r_cam;
        end
        if (i_cmd.rd_load) begin
            r_rdx <= RD_W'(c_trx + r_dir_x);
            r_rdy <= RD_W'(c_try + r_dir_y);
        end
        if (i_cmd.dx_load) begin
            r_ddx <= (r_rdx == '0) ? DELTA_INF : DD_W'(w_quo);
        end
        if (i_cmd.dy_load) begin
            r_ddy <= (r_rdy == '0) ? DELTA_INF : DD_W'(w_quo);
        end
        if (i_cmd.sd_load) begin
            r_sdx <= r_ddx[DD_W-1] ? SD_W'({c_fracx, 24'b0}) : SD_W'(c_pmx[47:16]);
            r_sdy <= r_ddy[DD_W-1] ? SD_W'({c_fracy, 24'b0}) : SD_W'(c_pmy[47:16]);
            r_mx  <= MX_W'(r_pos_x[16 +: MAP_BITS]);
            r_my  <= MX_W'(r_pos_y[16 +: MAP_BITS]);
        end
        if (i_cmd.step) begin
            r_mx <= c_mx;
            r_my <= c_my;
            if (c_take_x) begin
                r_sdx  <= r_sdx + SD_W'(r_ddx);
                r_side <= 1'b0;
            end else begin
                r_sdy  <= r_sdy + SD_W'(r_ddy);
                r_side <= 1'b1;
            end
        end
        if (i_cmd.wall_load) begin
            r_wall <= w_rdata;
        end
        if (i_cmd.lh_load) begin
            // a zero distance divides to all ones and saturates here too
            r_lh <= (w_quo >= DIV_NW'(LH_MAX)) ? LH_W'(LH_MAX) : w_quo[LH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 1'b0;
        end else if (i_cmd.accept_cast) begin
            r_left <= 1'b0;
        end else if (i_cmd.mark_left) begin
            r_left <= 1'b1;
        end
    end

    // vertical span
    assign c_hh      = r_h[11:1];
    assign c_lh2     = r_lh[LH_W-1:1];
    assign c_start   = ({1'b0, c_hh} > c_lh2) ? c_hh - c_lh2[10:0] : 11'd0;
    assign c_end_sum = 13'(c_lh2) + 13'(c_hh);
    assign c_end     = (c_end_sum >= 13'(r_h)) ? 11'(r_h - 12'd1) : c_end_sum[10:0];
    assign c_dist    = (c_perp > SD_W'(DIST_MAX)) ? DIST_MAX : c_perp[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_column <= r_col;
            r_out.left_map   <= r_left;
            if (r_left) begin
                r_out.draw_start    <= '0;
                r_out.draw_end      <= '0;
                r_out.wall_type     <= '0;
                r_out.hit_side      <= 1'b0;
                r_out.wall_distance <= '0;
            end else begin
                r_out.draw_start    <= c_start;
                r_out.draw_end      <= c_end;
                r_out.wall_type     <= r_wall;
                r_out.hit_side      <= r_side;
                r_out.wall_distance <= c_dist;
            end
        end
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.start_out = (r_pos_x[23:16+MAP_BITS] != '0) || (r_pos_y[23:16+MAP_BITS] != '0);
    assign o_stat.step_out  = (c_mx[MX_W-1:MAP_BITS] != '0) || (c_my[MX_W-1:MAP_BITS] != '0);
    assign o_stat.wall_nz   = w_rdata != 8'd0;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: sv/gdr_ctrl.sv
module gdr_ctrl
    import gdr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_command,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CAM_GO   = 4'd1;
    localparam logic [3:0] S_CAM_WAIT = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_RD       = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_DX_WAIT  = 4'd6;
    localparam logic [3:0] S_DY_GO    = 4'd7;
    localparam logic [3:0] S_DY_WAIT  = 4'd8;
    localparam logic [3:0] S_SD       = 4'd9;
    localparam logic [3:0] S_STEP     = 4'd10;
    localparam logic [3:0] S_TEST     = 4'd11;
    localparam logic [3:0] S_LH_GO    = 4'd12;
    localparam logic [3:0] S_LH_WAIT  = 4'd13;
    localparam logic [3:0] S_FIN      = 4'd14;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept_write = i_in_valid && !i_in_command;
                o_cmd.accept_cast  = i_in_valid && i_in_command;
                if (i_in_valid && i_in_command) begin
                    n_state = S_CAM_GO;
                end
            end
            S_CAM_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_CAM;
                n_state         = S_CAM_WAIT;
            end
            S_CAM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cam_load = 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.rd_load = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.start_out) begin
                    o_cmd.mark_left = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_DX;
                    n_state         = S_DX_WAIT;
                end
            end
            S_DX_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.dx_load = 1'b1;
                    n_state       = S_DY_GO;
                end
            end
            S_DY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_DY;
                n_state         = S_DY_WAIT;
            end
            S_DY_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.dy_load = 1'b1;
                    n_state       = S_SD;
                end
            end
            S_SD: begin
                o_cmd.sd_load = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                if (i_stat.step_out) begin
                    o_cmd.mark_left = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    // map read is issued with the step
                    o_cmd.step = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.wall_load = 1'b1;
                n_state         = i_stat.wall_nz ? S_LH_GO : S_STEP;
            end
            S_LH_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_LH;
                n_state         = S_LH_WAIT;
            end
            S_LH_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.lh_load = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/grid_dda_raycast_column.sv
// Column raycaster over a 64 x 64 wall map.
// Input channel (i_in_valid / o_in_ready) carries one word: a map cell write
// or a column cast. A write gives no result. A cast gives one result word on
// the output channel (o_out_valid / i_out_ready).
// Configuration (camera, screen size) is written through i_cfg_we, i_cfg_index
// and i_cfg_data by the user, only while the block is idle; the block itself
// does not enforce this. A write lands at once. A cast runs up to four serial
// divisions of 31 quotient bits (camera offset, two step lengths, line height)
// and a walk loop that steps one cell and reads the map memory on each pass.
// A walk crosses at most about 128 cells.
// One cast is worked at a time; the next word is taken as soon as the result
// has moved into the output register, even while that result waits.
// When the receiver stalls, a finished cast holds until the output register
// frees, and no further word is taken meanwhile.
// Synchronous reset clears the control state and restores register defaults;
// the map contents are undefined until written.
module grid_dda_raycast_column
    import gdr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_cmd  w_cmd;
    t_stat w_stat;

    gdr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_word.command),
        .i_stat       (w_stat),
        .o_in_ready   (o_in_ready),
        .o_cmd        (w_cmd)
    );

    gdr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
